/* hw/rtl/big5_text_layout_parser_core_macros.svh */
// assertion macros for the big5 text layout parser core
`ifndef BIG5_TEXT_LAYOUT_PARSER_CORE_MACROS_SVH
`define BIG5_TEXT_LAYOUT_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define B5TLP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define B5TLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/b5tlp_pkg.sv */
// shared types, constants and helper functions for the big5 text layout parser
package b5tlp_pkg;

	localparam int unsigned GLYPH_WIDTH  = 12;
	localparam int unsigned GLYPH_HEIGHT = 12;
	localparam int unsigned HALF_WIDTH   = 6;
	localparam int unsigned LINE_GAP     = 2;
	localparam int unsigned LINE_STEP    = GLYPH_HEIGHT + LINE_GAP;

	localparam int unsigned ORIGIN_W = 13;
	localparam int unsigned PEN_W    = 16;
	localparam int unsigned CODE_W   = 16;
	localparam int unsigned STEP_W   = 7;
	localparam int unsigned CFG_IDX_W = 1;

	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'd1;

	localparam logic [7:0] BYTE_NEWLINE = 8'h0A;

	typedef logic signed [PEN_W-1:0]    pen_t;
	typedef logic signed [ORIGIN_W-1:0] origin_t;

	typedef struct packed {
		logic [CODE_W-1:0] glyph_code;
		pen_t              pen_x;
		pen_t              pen_y;
		logic              full_width;
		logic              end_of_text;
	} out_item_t;

	function automatic logic is_lead(input logic [7:0] b);
		return b inside {[8'hA1:8'hFE]};
	endfunction

	function automatic logic is_trail(input logic [7:0] b);
		return b inside {[8'h40:8'h7E], [8'hA1:8'hFE]};
	endfunction

	function automatic logic is_printable(input logic [7:0] b);
		return b inside {[8'h20:8'h7E]};
	endfunction

	// positive step only, so only the upper limit can be hit
	function automatic pen_t sat_add(input pen_t a, input logic [STEP_W-1:0] inc);
		logic [PEN_W:0] s;
		s = {a[PEN_W-1], a} + (PEN_W+1)'(inc);
		if (!a[PEN_W-1] && s[PEN_W-1])
			return {1'b0, {(PEN_W-1){1'b1}}};
		return pen_t'(s[PEN_W-1:0]);
	endfunction

	function automatic pen_t widen(input origin_t o);
		return pen_t'(o);
	endfunction

endpackage

/* hw/rtl/b5tlp_if.sv */
// handshake interfaces for the byte input, result output and register write channels
interface b5tlp_in_if import b5tlp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, text_byte, final_byte, input ready);
	modport sink (input valid, text_byte, final_byte, output ready);
endinterface

interface b5tlp_out_if import b5tlp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] glyph_code;
	pen_t              pen_x;
	pen_t              pen_y;
	logic              full_width;
	logic              end_of_text;

	modport source (output valid, glyph_code, pen_x, pen_y, full_width, end_of_text,
		input ready);
	modport sink (input valid, glyph_code, pen_x, pen_y, full_width, end_of_text,
		output ready);
endinterface

interface b5tlp_cfg_if import b5tlp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	origin_t              data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/big5_text_layout_parser_core.sv */
// big5 byte stream to glyph placement command parser, top level
//
//  channel    dir  payload                                          
//  cfg        in   index, data (origin_x / origin_y)
//  text_in    in   text_byte, final_byte
//  glyph_out  out  glyph_code, pen_x, pen_y, full_width, end_of_text
//
// one byte per cycle while ready; state update and result build sit in the accept cycle
// a byte gives zero, one or two results, drained one per ready cycle from a 4 entry queue
// text_in is ready while the queue has room for two results
// a cfg write beats the byte's state update; reset clears the queue and pen state
`include "big5_text_layout_parser_core_macros.svh"

module big5_text_layout_parser_core import b5tlp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	b5tlp_cfg_if.sink  cfg,
	b5tlp_in_if.sink   text_in,
	b5tlp_out_if.source glyph_out
);

	origin_t    origin_x_q, origin_y_q;
	logic [7:0] held_lead_q;
	logic       lead_pending_q;
	pen_t       cursor_x_q, cursor_y_q;

	out_item_t             oq_mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0]   cnt_q;

	logic       in_xfer, out_xfer, cfg_xfer;
	logic [7:0] b;
	logic       fin, wide, narrow, newline, emit, take_lead;
	pen_t       cx_after, cy_after;
	out_item_t  glyph_item, end_item, first_item;
	logic [1:0] push_n;

	assign cfg.ready     = 1'b1;
	assign cfg_xfer      = cfg.valid && cfg.ready;
	assign text_in.ready = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign in_xfer       = text_in.valid && text_in.ready;
	assign out_xfer      = glyph_out.valid && glyph_out.ready;

	always_comb begin
		b         = text_in.text_byte;
		fin       = text_in.final_byte;
		wide      = lead_pending_q && is_trail(b);
		narrow    = !wide && is_printable(b);
		newline   = !wide && (b == BYTE_NEWLINE);
		take_lead = !wide && is_lead(b) && !fin;
		emit      = wide || narrow;

		cx_after = cursor_x_q;
		cy_after = cursor_y_q;
		if (wide) begin
			cx_after = sat_add(cursor_x_q, STEP_W'(GLYPH_WIDTH));
		end else if (narrow) begin
			cx_after = sat_add(cursor_x_q, STEP_W'(HALF_WIDTH));
		end else if (newline) begin
			cx_after = widen(origin_x_q);
			cy_after = sat_add(cursor_y_q, STEP_W'(LINE_STEP));
		end

		glyph_item.glyph_code  = wide ? {held_lead_q, b} : {8'h00, b};
		glyph_item.pen_x       = cursor_x_q;
		glyph_item.pen_y       = cursor_y_q;
		glyph_item.full_width  = wide;
		glyph_item.end_of_text = 1'b0;

		end_item.glyph_code  = '0;
		end_item.pen_x       = cx_after;
		end_item.pen_y       = cy_after;
		end_item.full_width  = 1'b0;
		end_item.end_of_text = 1'b1;

		first_item = emit ? glyph_item : end_item;
		push_n     = in_xfer ? (2'(emit) + 2'(fin)) : 2'd0;
	end

	// pen and lead state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			held_lead_q    <= '0;
			lead_pending_q <= 1'b0;
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
		end else if (cfg_xfer) begin
			case (cfg.index)
				REG_ORIGIN_X: begin
					origin_x_q <= cfg.data;
					cursor_x_q <= widen(cfg.data);
				end
				REG_ORIGIN_Y: begin
					origin_y_q <= cfg.data;
					cursor_y_q <= widen(cfg.data);
				end
				default: ;
			endcase
		end else if (in_xfer) begin
			lead_pending_q <= take_lead;
			if (take_lead)
				held_lead_q <= b;
			if (fin) begin
				held_lead_q <= '0;
				cursor_x_q  <= widen(origin_x_q);
				cursor_y_q  <= widen(origin_y_q);
			end else begin
				cursor_x_q <= cx_after;
				cursor_y_q <= cy_after;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			oq_mem_q[wr_ptr_q] <= first_item;
		if (push_n == 2'd2)
			oq_mem_q[wr_ptr_q + OQ_PTR_W'(1)] <= end_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_n);
			if (out_xfer)
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			cnt_q <= cnt_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(out_xfer);
		end
	end

	assign glyph_out.valid       = (cnt_q != '0);
	assign glyph_out.glyph_code  = oq_mem_q[rd_ptr_q].glyph_code;
	assign glyph_out.pen_x       = oq_mem_q[rd_ptr_q].pen_x;
	assign glyph_out.pen_y       = oq_mem_q[rd_ptr_q].pen_y;
	assign glyph_out.full_width  = oq_mem_q[rd_ptr_q].full_width;
	assign glyph_out.end_of_text = oq_mem_q[rd_ptr_q].end_of_text;

	`B5TLP_ASSERT_NOW(a_oq_bound, 1'b1, cnt_q <= OQ_CNT_W'(OQ_DEPTH), "result queue overfilled")
	`B5TLP_ASSERT_NEXT(a_fin_clears_lead, in_xfer && fin && !cfg_xfer, !lead_pending_q, "lead held past end of text")
	`B5TLP_ASSERT_NEXT(a_fin_home_x, in_xfer && fin && !cfg_xfer, cursor_x_q == widen(origin_x_q), "pen x not returned after end of text")
	`B5TLP_ASSERT_NOW(a_ready_room, !text_in.ready, cnt_q > OQ_CNT_W'(OQ_DEPTH - 2), "input stalled with queue room")

endmodule

/* test/big5_text_layout_parser_core_tb.sv */
`timescale 1ns / 100ps
// testbench for the big5 text layout parser core: directed and random byte streams checked against a layout predictor
module big5_text_layout_parser_core_tb;
	import b5tlp_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int LONG_HOLD     = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int PEN_MAX       = 32767;

	logic clk = 1'b0;
	logic arst_n;

	b5tlp_cfg_if cfg_bus ();
	b5tlp_in_if  byte_bus ();
	b5tlp_out_if cmd_bus ();

	big5_text_layout_parser_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_bus),
		.text_in   (byte_bus),
		.glyph_out (cmd_bus)
	);

	// pen and lead state as the block should hold it
	int         org_x = 0;
	int         org_y = 0;
	int         cur_x = 0;
	int         cur_y = 0;
	logic [7:0] lead_byte = 8'h00;
	bit         lead_held = 1'b0;
	out_item_t  due_cmds[$];

	int fail_count   = 0;
	int cmds_checked = 0;
	int live_bytes   = 0;
	int reg_writes   = 0;
	int quiet_cycles = 0;
	bit idle_on      = 1'b1;
	bit hold_req     = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic out_item_t make_cmd(logic [CODE_W-1:0] code, int x, int y, logic fw,
		logic eot);
		out_item_t c;
		c.glyph_code  = code;
		c.pen_x       = pen_t'(x);
		c.pen_y       = pen_t'(y);
		c.full_width  = fw;
		c.end_of_text = eot;
		return c;
	endfunction

	function automatic int sat_pen(int v);
		return (v > PEN_MAX) ? PEN_MAX : v;
	endfunction

	function automatic void lay_out_byte(logic [7:0] b, logic fin);
		bit done;
		bit was_held;
		bit is_ld;
		bit is_pr;
		done     = 1'b0;
		was_held = lead_held;
		is_ld    = (b >= 8'hA1 && b <= 8'hFE);
		is_pr    = (b >= 8'h20 && b <= 8'h7E);
		if (lead_held) begin
			lead_held = 1'b0;
			if ((b >= 8'h40 && b <= 8'h7E) || is_ld) begin
				due_cmds.push_back(make_cmd({lead_byte, b}, cur_x, cur_y, 1'b1, 1'b0));
				cur_x = sat_pen(cur_x + int'(GLYPH_WIDTH));
				done = 1'b1;
			end
		end
		if (!done) begin
			if (is_ld) begin
				if (!fin) begin
					lead_byte = b;
					lead_held = 1'b1;
				end
			end else if (is_pr) begin
				due_cmds.push_back(make_cmd({8'h00, b}, cur_x, cur_y, 1'b0, 1'b0));
				cur_x = sat_pen(cur_x + int'(HALF_WIDTH));
			end else if (b == BYTE_NEWLINE) begin
				cur_x = org_x;
				cur_y = sat_pen(cur_y + int'(LINE_STEP));
			end
		end
		if (fin) begin
			due_cmds.push_back(make_cmd('0, cur_x, cur_y, 1'b0, 1'b1));
			lead_held = 1'b0;
			lead_byte = 8'h00;
			cur_x     = org_x;
			cur_y     = org_y;
		end
		if (was_held || fin || is_ld || is_pr || b == BYTE_NEWLINE)
			live_bytes++;
	endfunction

	function automatic logic [7:0] rand_print();
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	function automatic logic [7:0] rand_lead();
		return 8'($urandom_range(8'hA1, 8'hFE));
	endfunction

	function automatic logic [7:0] rand_trail();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(8'h40, 8'h7E));
		return rand_lead();
	endfunction

	function automatic logic [7:0] rand_non_trail();
		case ($urandom_range(0, 2))
			0: return 8'($urandom_range(8'h00, 8'h3F));
			1: return 8'($urandom_range(8'h7F, 8'hA0));
			default: return 8'hFF;
		endcase
	endfunction

	function automatic logic [7:0] rand_skip();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while ((b >= 8'h20 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hFE) || b == BYTE_NEWLINE);
		return b;
	endfunction

	task automatic send_byte(logic [7:0] b, logic fin);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			byte_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_bus.valid      <= 1'b1;
		byte_bus.text_byte  <= b;
		byte_bus.final_byte <= fin;
		do @(posedge clk); while (!byte_bus.ready);
		lay_out_byte(b, fin);
	endtask

	task automatic send_glyph(logic fin);
		send_byte(rand_lead(), 1'b0);
		send_byte(rand_trail(), fin);
	endtask

	task automatic send_random_string(int len);
		bit last;
		for (int i = 0; i < len; i++) begin
			last = (i == len - 1);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_byte(rand_print(), last);
				4, 5: send_glyph(last);
				6: send_byte(BYTE_NEWLINE, last);
				7: send_byte(rand_skip(), last);
				8: begin
					send_byte(rand_lead(), 1'b0);
					send_byte(rand_non_trail(), last);
				end
				default: send_byte(rand_lead(), last);
			endcase
		end
	endtask

	task automatic drain_all();
		byte_bus.valid <= 1'b0;
		do @(posedge clk); while (due_cmds.size() != 0);
	endtask

	// a held lead gives no result, so let the pipeline empty before touching registers
	task automatic settle();
		drain_all();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, origin_t val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_ORIGIN_X: begin
				org_x = int'(val);
				cur_x = org_x;
			end
			REG_ORIGIN_Y: begin
				org_y = int'(val);
				cur_y = org_y;
			end
			default: ;
		endcase
		reg_writes++;
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_origin(origin_t x, origin_t y);
		settle();
		write_reg(REG_ORIGIN_X, x);
		write_reg(REG_ORIGIN_Y, y);
	endtask

	task automatic test_directed();
		set_origin(origin_t'(0), origin_t'(0));
		send_byte(8'h20, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'hA1, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hA1, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hA1, 1'b0);
		send_byte(BYTE_NEWLINE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h1F, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'hFF, 1'b0);
		// invalid trail falls back to ascii, then to newline
		send_byte(8'hB0, 1'b0);
		send_byte(8'h30, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(BYTE_NEWLINE, 1'b0);
		send_byte(8'hA4, 1'b0);
		send_byte(8'h41, 1'b1);
		// lone lead on the last byte is dropped
		send_byte(8'hA5, 1'b1);
		settle();
	endtask

	task automatic test_held_lead_config();
		set_origin(origin_t'(-20), origin_t'(30));
		send_byte(8'h41, 1'b0);
		send_byte(8'hA7, 1'b0);
		settle();
		write_reg(REG_ORIGIN_X, origin_t'(100));
		send_byte(8'h60, 1'b0);
		send_byte(8'hA8, 1'b0);
		settle();
		write_reg(REG_ORIGIN_Y, origin_t'(-50));
		send_byte(8'hA9, 1'b1);
		settle();
	endtask

	task automatic test_extreme_origins();
		origin_t ex_x[4] = '{origin_t'(-4096), origin_t'(4095), origin_t'(-4096), origin_t'(4095)};
		origin_t ex_y[4] = '{origin_t'(-4096), origin_t'(4095), origin_t'(4095), origin_t'(-4096)};
		for (int i = 0; i < 4; i++) begin
			set_origin(ex_x[i], ex_y[i]);
			send_random_string(12);
			send_random_string(6);
		end
	endtask

	task automatic test_backpressure();
		idle_on  = 1'b0;
		hold_req = 1'b1;
		repeat (3) send_random_string(15);
		drain_all();
		idle_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		send_byte(8'h41, 1'b0);
		send_byte(8'hB1, 1'b0);
		drain_all();
		send_byte(8'h62, 1'b1);
		for (int i = 0; i < 20; i++) begin
			send_random_string($urandom_range(3, 10));
			drain_all();
		end
	endtask

	task automatic test_random();
		int target;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: set_origin(origin_t'(-4096), origin_t'(4095));
				2: set_origin(origin_t'(4095), origin_t'(-4096));
				default: set_origin(origin_t'($urandom_range(0, 8191)),
					origin_t'($urandom_range(0, 8191)));
			endcase
			target = live_bytes + 230;
			while (live_bytes < target) begin
				idle_on = (phase < 5) && ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 8))
						send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
				end else
					send_random_string($urandom_range(1, 30));
			end
		end
		idle_on = 1'b0;
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		cmd_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				cmd_bus.ready <= 1'b0;
				hold_req = 1'b0;
				for (int n = 1; n < LONG_HOLD; n++)
					@(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				cmd_bus.ready <= 1'b0;
				repeat ($urandom_range(0, 8)) @(posedge clk);
			end else
				cmd_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			got = '{cmd_bus.glyph_code, cmd_bus.pen_x, cmd_bus.pen_y, cmd_bus.full_width,
				cmd_bus.end_of_text};
			if (due_cmds.size() == 0) begin
				$display("%0t: unexpected transfer code %h x %0d y %0d fw %b end %b", $time,
					got.glyph_code, got.pen_x, got.pen_y, got.full_width, got.end_of_text);
				fail_count++;
			end else begin
				want = due_cmds.pop_front();
				cmds_checked++;
				if (got !== want) begin
					$display("%0t: expected code %h x %0d y %0d fw %b end %b", $time,
						want.glyph_code, want.pen_x, want.pen_y, want.full_width,
						want.end_of_text);
					$display("%0t:   actual code %h x %0d y %0d fw %b end %b", $time,
						got.glyph_code, got.pen_x, got.pen_y, got.full_width, got.end_of_text);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_bus.valid && byte_bus.ready) || (cmd_bus.valid && cmd_bus.ready) ||
			(cfg_bus.valid && cfg_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
				QUIET_LIMIT, due_cmds.size());
			$display("** big5_text_layout_parser_core: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n              <= 1'b0;
		byte_bus.valid      <= 1'b0;
		byte_bus.text_byte  <= 8'h00;
		byte_bus.final_byte <= 1'b0;
		cfg_bus.valid       <= 1'b0;
		cfg_bus.index       <= REG_ORIGIN_X;
		cfg_bus.data        <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_held_lead_config();
		test_extreme_origins();
		test_backpressure();
		test_drain_pause();
		test_random();
		settle();
		$display("covered %0d live text bytes, %0d checked commands, %0d register writes",
			live_bytes, cmds_checked, reg_writes);
		$display("incl. bad trails, final leads, origin extremes, output stalls");
		if (fail_count == 0)
			$display("** big5_text_layout_parser_core: PASSED **");
		else
			$display("** big5_text_layout_parser_core: FAILED **");
		$finish;
	end

endmodule
